// ===== hw/rtl/urrb_pkg.sv =====
// Shared types and constants for the UART receive ring buffer.
package urrb_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int BYTE_W    = 8;
    localparam int ACT_W     = 2;
    localparam int ERR_W     = 3;
    localparam int COUNT_W   = 6;

    // Byte stored in place of a received byte that carried a line error ('X').
    localparam logic [BYTE_W-1:0] ERROR_MARK = 8'h58;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd4;

    typedef enum logic [ACT_W-1:0] {
        ACT_RECEIVE = 2'd0,
        ACT_POP     = 2'd1,
        ACT_FLUSH   = 2'd2
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_DONE
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic exec;   // request accepted this cycle: update ring state
        logic load;   // move the finished result into the output register
    } dp_cmd_t;

endpackage

// ===== hw/rtl/uart_receive_ring_buffer.sv =====
// Top level of the UART receive ring buffer.
// Usage:
//   Input channel (in_valid/in_ready) carries one request: action selects
//   receive (store rx_byte, or 'X' when frame_error/overrun_error is set),
//   pop (return the oldest byte) or flush (drop everything held).
//   Output channel (out_valid/out_ready) returns one result per request:
//   data_byte (popped byte, else 0), error_status (last error: none, frame,
//   overrun, both, buffer overflow), no_data (pop found the ring empty) and
//   bytes_waiting (bytes held after the request, low 6 bits).
//   The ring holds DEPTH-1 bytes; a receive into a full ring drops the byte
//   and sets error_status to buffer overflow.
// Timing:
//   An accepted request updates the ring state and moves to ST_DONE, which loads the
//   result into the output register. One request is in work at a time; a pop waits
//   in ST_DONE on the byte store's registered read.
//   A finished result sits in the output register; the next request is
//   accepted while it waits. If the receiver stalls, the following result
//   holds in the datapath and no further request is taken.
// Reset:
//   rst_n clears both ring pointers, the last error and out_valid; store kept.
module uart_receive_ring_buffer #(
    parameter int DEPTH = urrb_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [urrb_pkg::ACT_W-1:0]    action,
    input  logic [urrb_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          frame_error,
    input  logic                          overrun_error,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [urrb_pkg::BYTE_W-1:0]   data_byte,
    output logic [urrb_pkg::ERR_W-1:0]    error_status,
    output logic                          no_data,
    output logic [urrb_pkg::COUNT_W-1:0]  bytes_waiting
);
    import urrb_pkg::*;

    dp_cmd_t cmd;

    // Sequencing: accept, update ring state, then hand off the result.
    urrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Pointers, last error, byte store and output register.
    urrb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .rx_byte       (rx_byte),
        .frame_error   (frame_error),
        .overrun_error (overrun_error),
        .data_byte     (data_byte),
        .error_status  (error_status),
        .no_data       (no_data),
        .bytes_waiting (bytes_waiting)
    );

endmodule

// ===== hw/rtl/urrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module urrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/urrb_ctrl.sv =====
// Handshake controller for the receive ring buffer.
module urrb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output urrb_pkg::dp_cmd_t cmd
);
    import urrb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // output slot free, or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_load_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while one is in work");

endmodule

// ===== hw/rtl/urrb_dp.sv =====
// Ring pointers, error status, byte store and result registers.
module urrb_dp #(
    parameter int DEPTH = urrb_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  urrb_pkg::dp_cmd_t             cmd,
    input  logic [urrb_pkg::ACT_W-1:0]    action,
    input  logic [urrb_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          frame_error,
    input  logic                          overrun_error,
    output logic [urrb_pkg::BYTE_W-1:0]   data_byte,
    output logic [urrb_pkg::ERR_W-1:0]    error_status,
    output logic                          no_data,
    output logic [urrb_pkg::COUNT_W-1:0]  bytes_waiting
);
    import urrb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic               nodata_reg, nodata_next;
    logic               hit_reg, hit_next;

    logic [BYTE_W-1:0]  data_byte_reg;
    logic [ERR_W-1:0]   error_status_reg;
    logic               no_data_reg;
    logic [COUNT_W-1:0] bytes_waiting_reg;

    logic [PTR_W-1:0]   wr_inc;
    logic [PTR_W-1:0]   rd_inc;
    logic [ERR_W-1:0]   line_err;
    logic [PTR_W:0]     cnt_wide;
    logic [PTR_W-1:0]   count;

    logic               ram_we;
    logic               ram_re;
    logic [BYTE_W-1:0]  ram_wdata;
    logic [BYTE_W-1:0]  ram_rdata;

    assign wr_inc   = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
    assign rd_inc   = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
    assign line_err = {1'b0, overrun_error, frame_error};

    // (wr - rd) mod DEPTH
    assign cnt_wide = (wr_reg >= rd_reg)
                    ? {1'b0, wr_reg} - {1'b0, rd_reg}
                    : {1'b0, wr_reg} + (PTR_W+1)'(DEPTH) - {1'b0, rd_reg};
    assign count    = cnt_wide[PTR_W-1:0];

    always_comb
    begin
        wr_next     = wr_reg;
        rd_next     = rd_reg;
        err_next    = err_reg;
        nodata_next = nodata_reg;
        hit_next    = hit_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = (line_err != ERR_NONE) ? ERROR_MARK : rx_byte;
        if (cmd.exec)
        begin
            nodata_next = 1'b0;
            hit_next    = 1'b0;
            case (action)
                ACT_RECEIVE:
                begin
                    if (wr_inc == rd_reg)
                    begin
                        err_next = ERR_OVERFLOW;
                    end
                    else
                    begin
                        err_next = line_err;
                        wr_next  = wr_inc;
                        ram_we   = 1'b1;
                    end
                end
                ACT_POP:
                begin
                    if (wr_reg == rd_reg)
                    begin
                        nodata_next = 1'b1;
                    end
                    else
                    begin
                        rd_next  = rd_inc;
                        ram_re   = 1'b1;
                        hit_next = 1'b1;
                    end
                end
                ACT_FLUSH:
                begin
                    wr_next = rd_reg;
                end
                default:
                begin
                    wr_next = wr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            err_reg <= ERR_NONE;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nodata_reg <= nodata_next;
        hit_reg    <= hit_next;
        if (cmd.load)
        begin
            data_byte_reg     <= hit_reg ? ram_rdata : '0;
            error_status_reg  <= err_reg;
            no_data_reg       <= nodata_reg;
            bytes_waiting_reg <= COUNT_W'(count);
        end
    end

    urrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_inc),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_inc),
        .rdata (ram_rdata)
    );

    assign data_byte     = data_byte_reg;
    assign error_status  = error_status_reg;
    assign no_data       = no_data_reg;
    assign bytes_waiting = bytes_waiting_reg;

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_reg <= PTR_W'(DEPTH - 1)) && (rd_reg <= PTR_W'(DEPTH - 1)))
        else $error("ring pointer out of range");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && action == ACT_FLUSH) |=> (wr_reg == rd_reg))
        else $error("flush left bytes in the ring");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && action == ACT_POP && wr_reg == rd_reg)
        |=> (nodata_reg && !hit_reg && $stable(rd_reg)))
        else $error("pop on empty ring moved the read pointer");

endmodule
